FILE: rtl/core/hrf_pkg.sv
// Shared types, character constants and lookup functions for the HTTP request framer.
package hrf_pkg;

  // Command carried with each input word.
  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_t;

  // Content-Length parse phase, one-hot.
  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_SPACES = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Status from the header scanner to the slot queue.
  typedef struct packed {
    logic hdr_done;
    logic complete;
  } scan_status_t;

  // Per-word decision from the slot queue.
  typedef struct packed {
    logic       request_ready;
    logic [2:0] slot_index;
    logic       queue_full;
    logic       queue_empty;
    logic       clear_req;
  } queue_result_t;

  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_NINE    = 8'h39;
  localparam logic [7:0]  CH_CAP_C   = 8'h43;
  localparam logic [7:0]  CH_CAP_A   = 8'h41;
  localparam logic [7:0]  CH_CAP_Z   = 8'h5A;
  localparam logic [7:0]  CASE_DELTA = 8'h20;
  localparam logic [3:0]  NAME_LAST  = 4'd14;
  localparam logic [1:0]  BLANK_LAST = 2'd3;
  localparam logic [35:0] DEC_BASE   = 36'd10;
  localparam logic [31:0] LEN_SAT    = 32'h7FFF_FFFF;
  localparam logic [31:0] LEN_NONE   = 32'hFFFF_FFFF;

  // Fold an upper-case letter to lower case.
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_CAP_A && c <= CH_CAP_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

  // Lower-case letters of the header name "Content-Length:".
  function automatic logic [7:0] name_lc(input logic [3:0] pos);
    logic [7:0] r;
    unique case (pos)
      4'd0:    r = 8'h63; // c
      4'd1:    r = 8'h6F; // o
      4'd2:    r = 8'h6E; // n
      4'd3:    r = 8'h74; // t
      4'd4:    r = 8'h65; // e
      4'd5:    r = 8'h6E; // n
      4'd6:    r = 8'h74; // t
      4'd7:    r = 8'h2D; // -
      4'd8:    r = 8'h6C; // l
      4'd9:    r = 8'h65; // e
      4'd10:   r = 8'h6E; // n
      4'd11:   r = 8'h67; // g
      4'd12:   r = 8'h74; // t
      4'd13:   r = 8'h68; // h
      4'd14:   r = 8'h3A; // :
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Expected character of the blank-line sequence CR LF CR LF.
  function automatic logic [7:0] blank_char(input logic [1:0] idx);
    return idx[0] ? CH_LF : CH_CR;
  endfunction

endpackage

FILE: rtl/core/http_request_framer_core.sv
// Top level of the HTTP request framer: input register, scanner, slot queue, result register.
// Path: an accepted word passes through the input register, then the result register.
// Throughput: one word per cycle unless out_ready stalls; the input register and the
// result register let a new word enter while a finished result still waits for out_ready.
// Reset: synchronous, active low; clears both registers' valid flags, the slot pointers
// and the per-request parse state (declared length reads as not yet known).
module http_request_framer_core #(
  parameter int QUEUE_SLOTS   = 8,
  parameter int REQUEST_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [7:0]         in_data_byte,
  input  logic               in_segment_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_request_ready,
  output logic [2:0]         out_slot_index,
  output logic               out_headers_complete,
  output logic signed [31:0] out_declared_length,
  output logic [11:0]        out_body_length,
  output logic               out_queue_full,
  output logic               out_queue_empty
);
  import hrf_pkg::*;

  logic          in_valid_r;
  logic          in_cmd_r;
  logic [7:0]    in_byte_r;
  logic          in_seg_r;
  logic          advance;
  logic          scan_en;
  scan_status_t  status;
  queue_result_t qres;
  logic [31:0]   scan_declared;
  logic [11:0]   scan_body;

  logic          out_valid_r;
  logic          out_request_ready_r;
  logic [2:0]    out_slot_index_r;
  logic          out_headers_complete_r;
  logic [31:0]   out_declared_length_r;
  logic [11:0]   out_body_length_r;
  logic          out_queue_full_r;
  logic          out_queue_empty_r;

  // A word moves on when the result register is free or being emptied.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign scan_en  = advance && (in_cmd_r == CMD_BYTE);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_data_byte;
      in_seg_r  <= in_segment_end;
    end
  end

  hrf_hdr_scan #(
    .REQUEST_BYTES(REQUEST_BYTES)
  ) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (scan_en),
    .data_byte      (in_byte_r),
    .clear_req      (qres.clear_req),
    .status         (status),
    .declared_length(scan_declared),
    .body_length    (scan_body)
  );

  hrf_slot_queue #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .cmd        (in_cmd_r),
    .segment_end(in_seg_r),
    .status     (status),
    .result     (qres)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; dequeue words report no header information.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_request_ready_r <= qres.request_ready;
      out_slot_index_r    <= qres.slot_index;
      out_queue_full_r    <= qres.queue_full;
      out_queue_empty_r   <= qres.queue_empty;
      if (in_cmd_r == CMD_DEQUEUE) begin
        out_headers_complete_r <= 1'b0;
        out_declared_length_r  <= '0;
        out_body_length_r      <= '0;
      end else begin
        out_headers_complete_r <= status.hdr_done;
        out_declared_length_r  <= scan_declared;
        out_body_length_r      <= scan_body;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_request_ready    = out_request_ready_r;
  assign out_slot_index       = out_slot_index_r;
  assign out_headers_complete = out_headers_complete_r;
  assign out_declared_length  = signed'(out_declared_length_r);
  assign out_body_length      = out_body_length_r;
  assign out_queue_full       = out_queue_full_r;
  assign out_queue_empty      = out_queue_empty_r;

endmodule

FILE: rtl/core/hrf_hdr_scan.sv
// Header scanner: blank-line detector, Content-Length matcher and parser, byte counters.
module hrf_hdr_scan #(
  parameter int REQUEST_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          data_byte,
  input  logic                clear_req,
  output hrf_pkg::scan_status_t status,
  output logic [31:0]         declared_length,
  output logic [11:0]         body_length
);
  import hrf_pkg::*;

  localparam int CNT_W = $clog2(REQUEST_BYTES);
  localparam int EXT_W = (CNT_W > 12) ? CNT_W : 12;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(REQUEST_BYTES - 1);

  logic [CNT_W-1:0] stored_r, stored_nxt;
  logic [CNT_W-1:0] header_r, header_nxt;
  logic             hdr_seen_r, hdr_seen_nxt;
  logic [1:0]       progress_r, progress_nxt;
  logic [3:0]       pos_r, pos_nxt;
  phase_t           phase_r, phase_nxt;
  logic [31:0]      value_r, value_nxt;

  logic             keep;
  logic             name_hit;
  logic             is_digit;
  logic [35:0]      dec_prod;
  logic [31:0]      dec_value;
  logic [CNT_W-1:0] body_diff;
  logic [EXT_W-1:0] body_ext;

  // Decimal accumulate with saturation at the largest positive 32-bit value.
  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign dec_prod  = 36'(value_r) * DEC_BASE + 36'(data_byte - CH_ZERO);
  assign dec_value = (|dec_prod[35:31]) ? LEN_SAT : dec_prod[31:0];

  // The first name character must be an exact capital C; the rest ignore case.
  assign name_hit = (pos_r == '0) ? (data_byte == CH_CAP_C)
                                  : (to_lower(data_byte) == name_lc(pos_r));
  assign keep     = (stored_r != CNT_MAX);

  // Next state for one request byte.
  always_comb begin
    stored_nxt   = stored_r;
    header_nxt   = header_r;
    hdr_seen_nxt = hdr_seen_r;
    progress_nxt = progress_r;
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    value_nxt    = value_r;
    if (keep) begin
      stored_nxt = stored_r + 1'b1;
      if (!hdr_seen_r) begin
        // Content-Length matcher and value parser.
        unique case (phase_r)
          PH_SEARCH: begin
            if (name_hit) begin
              if (pos_r == NAME_LAST) begin
                pos_nxt   = '0;
                phase_nxt = PH_SPACES;
                value_nxt = '0;
              end else begin
                pos_nxt = pos_r + 1'b1;
              end
            end else begin
              pos_nxt = (data_byte == CH_CAP_C) ? 4'd1 : 4'd0;
            end
          end
          PH_SPACES, PH_DIGITS: begin
            if (!(phase_r == PH_SPACES && data_byte == CH_SPACE)) begin
              if (is_digit) begin
                value_nxt = dec_value;
                phase_nxt = PH_DIGITS;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
          end
          PH_DONE: begin
            phase_nxt = PH_DONE;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
        // Blank-line detector; it sees the matcher's updated phase.
        if (data_byte == blank_char(progress_r)) begin
          if (progress_r == BLANK_LAST) begin
            progress_nxt = '0;
            hdr_seen_nxt = 1'b1;
            header_nxt   = stored_nxt;
            if (phase_nxt == PH_SEARCH) begin
              value_nxt = '0;
            end
          end else begin
            progress_nxt = progress_r + 1'b1;
          end
        end else begin
          progress_nxt = (data_byte == CH_CR) ? 2'd1 : 2'd0;
        end
      end
    end
  end

  // Result fields and completion test, taken from the updated state.
  assign body_diff       = stored_nxt - header_nxt;
  assign body_ext        = EXT_W'(body_diff);
  assign declared_length = hdr_seen_nxt ? value_nxt : LEN_NONE;
  assign body_length     = hdr_seen_nxt ? body_ext[11:0] : 12'd0;
  assign status.hdr_done = hdr_seen_nxt;
  assign status.complete = hdr_seen_nxt &&
                           ((value_nxt == '0) || (32'(body_diff) >= value_nxt));

  // State registers; a handed-off request starts the next slot from scratch.
  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && clear_req)) begin
      stored_r   <= '0;
      header_r   <= '0;
      hdr_seen_r <= 1'b0;
      progress_r <= '0;
      pos_r      <= '0;
      phase_r    <= PH_SEARCH;
      value_r    <= LEN_NONE;
    end else if (step_en) begin
      stored_r   <= stored_nxt;
      header_r   <= header_nxt;
      hdr_seen_r <= hdr_seen_nxt;
      progress_r <= progress_nxt;
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      value_r    <= value_nxt;
    end
  end

endmodule

FILE: rtl/core/hrf_slot_queue.sv
// Slot queue: write and read slot pointers, readiness hand-off and dequeue.
module hrf_slot_queue #(
  parameter int QUEUE_SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  cmd,
  input  logic                  segment_end,
  input  hrf_pkg::scan_status_t status,
  output hrf_pkg::queue_result_t result
);
  import hrf_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_SLOTS);
  localparam int SLOT_W = (PTR_W > 3) ? PTR_W : 3;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);

  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [PTR_W-1:0]  wr_inc, rd_inc;
  logic [SLOT_W-1:0] slot_ext;

  assign wr_inc = (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;

  // Decide hand-off or dequeue for the current word.
  always_comb begin
    wr_nxt               = wr_r;
    rd_nxt               = rd_r;
    result.request_ready = 1'b0;
    result.queue_full    = 1'b0;
    result.queue_empty   = 1'b0;
    result.clear_req     = 1'b0;
    if (cmd == CMD_DEQUEUE) begin
      slot_ext = SLOT_W'(rd_r);
      if (rd_r == wr_r) begin
        result.queue_empty = 1'b1;
      end else begin
        rd_nxt = rd_inc;
      end
    end else begin
      slot_ext = SLOT_W'(wr_r);
      if (segment_end && status.complete) begin
        result.request_ready = 1'b1;
        if (wr_inc != rd_r) begin
          wr_nxt           = wr_inc;
          result.clear_req = 1'b1;
        end else begin
          result.queue_full = 1'b1;
        end
      end
    end
    result.slot_index = slot_ext[2:0];
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else if (step_en) begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

endmodule

FILE: rtl/core/hrf_checker.sv
// Port-level checker for the HTTP request framer, bound to the top level.
module hrf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_request_ready,
  input logic [2:0]         out_slot_index,
  input logic               out_headers_complete,
  input logic signed [31:0] out_declared_length,
  input logic [11:0]        out_body_length,
  input logic               out_queue_full,
  input logic               out_queue_empty
);

  // No result word is presented in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot_index) &&
      $stable(out_request_ready) && $stable(out_declared_length) &&
      $stable(out_body_length))
    else $error("stalled result word changed");

  // A ready request always has complete headers and never comes from a dequeue.
  a_ready_has_headers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_ready |-> out_headers_complete && !out_queue_empty)
    else $error("ready request without complete headers");

  // Queue-full is only reported for a ready request.
  a_full_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_full |-> out_request_ready)
    else $error("queue full reported without a ready request");

  // The declared length is never negative other than the not-yet-known mark.
  a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_declared_length[31] || (out_declared_length == -32'sd1 &&
      !out_headers_complete))
    else $error("declared length out of range");

endmodule

bind http_request_framer_core hrf_checker u_hrf_checker (.*);
